/* rtl/rdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the radix digit converter
// Beat structs, the divider request/response groups and the glyph table.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // fixed field widths
  localparam int VALUE_BITS  = 16;
  localparam int BASE_BITS   = 5;
  localparam int CHAR_BITS   = 7;
  localparam int RDIG_BITS   = 4;

  // default width of the converted value
  localparam int VALUE_WIDTH_DEF = 16;

  // legal radix range
  localparam logic [BASE_BITS-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX = 5'd16;

  // error beat character
  localparam logic [CHAR_BITS-1:0] ERR_CHAR = 7'h00;

  // digit value to ascii
  localparam logic [CHAR_BITS-1:0] GLYPH [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
    logic                 bad_base;
  } out_beat_t;

  // request to the shared divider
  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [BASE_BITS-1:0]  divisor;
  } div_req_t;

  // divider status and results
  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [RDIG_BITS-1:0]  remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/rdc_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_divider: bit-serial restoring divider
// Divides a value by a radix of 2..16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rdc_divider
  import rdc_pkg::*;
#(
  parameter int QW = VALUE_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(QW + 1);

  logic [QW-1:0]        quo_r,  quo_nxt;
  logic [RDIG_BITS-1:0] rem_r,  rem_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [BASE_BITS-1:0] dvs_r,  dvs_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [BASE_BITS-1:0] trial;
  logic                 fits;

  // one shift-and-subtract step
  assign trial = {rem_r, quo_r[QW-1]};
  assign fits  = (trial >= dvs_r);

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend[QW-1:0];
      rem_nxt  = '0;
      step_nxt = STEP_W'(QW);
      dvs_nxt  = req.divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[QW-2:0], fits};
      rem_nxt  = fits ? RDIG_BITS'(trial - dvs_r) : trial[RDIG_BITS-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = VALUE_BITS'(quo_r);
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

/* rtl/radix_digit_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter: unsigned integer to ascii digits in radix 2..16
// Divides by the radix until the quotient is zero, then emits the digits.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one beat {value, base}.
//   out channel (out_valid/out_ready/out_data) gives one beat per digit,
//   most significant first, last_digit set on the final one.
//   A base outside 2..16 gives one beat with digit_char 0 and bad_base set.
//   Only the low VALUE_WIDTH bits of value (at most 16) are converted.
// Timing:
//   each digit takes one pass of the shared bit-serial divider over
//   QW = min(VALUE_WIDTH, 16) quotient bits; once all digits are found,
//   they are emitted one beat per cycle while out_ready is high.
//   in_ready is high only when the sequencer is idle.
// Reset and stall:
//   synchronous reset returns to idle with no output beat pending.
//   A stalled out_ready holds the current beat and pauses the digit readout.
// ----------------------------------------------------------------------------
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_beat_t      out_data
);

  localparam int QW    = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int IDX_W = $clog2(QW);
  localparam logic [VALUE_BITS-1:0] VALUE_MASK = VALUE_BITS'((33'd1 << QW) - 33'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [BASE_BITS-1:0] radix_r, radix_nxt;
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic                 err_r,   err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_beat_r,  out_beat_nxt;

  logic [RDIG_BITS-1:0] store_r [QW];
  logic                 store_we;
  logic [IDX_W-1:0]     rd_idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc;
  logic base_bad;
  logic slot_free;

  // shared divider
  rdc_divider #(
    .QW (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign base_bad  = (in_data.base < BASE_MIN) || (in_data.base > BASE_MAX);
  assign slot_free = !out_valid_r || out_ready;
  assign rd_idx    = IDX_W'(cnt_r - 1'b1);
  assign store_we  = (state_r == ST_DIVIDE) && div_rsp.done;

  // divider launch: first digit from the input, later ones from the quotient
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_r;
    if (in_acc) begin
      div_req.start    = !base_bad;
      div_req.dividend = in_data.value & VALUE_MASK;
      div_req.divisor  = in_data.base;
    end else if (store_we && (div_rsp.quotient != '0)) begin
      div_req.start = 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_beat_nxt  = out_beat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          err_nxt = base_bad;
          if (base_bad) begin
            state_nxt = ST_EMIT;
          end else begin
            radix_nxt = in_data.base;
            cnt_nxt   = '0;
            state_nxt = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          cnt_nxt = cnt_r + 1'b1;
          if (div_rsp.quotient == '0) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            out_beat_nxt.digit_char = ERR_CHAR;
            out_beat_nxt.last_digit = 1'b1;
            out_beat_nxt.bad_base   = 1'b1;
            state_nxt               = ST_IDLE;
          end else begin
            out_beat_nxt.digit_char = GLYPH[store_r[rd_idx]];
            out_beat_nxt.last_digit = (cnt_r == CNT_W'(1));
            out_beat_nxt.bad_base   = 1'b0;
            cnt_nxt                 = cnt_r - 1'b1;
            if (cnt_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      radix_r     <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radix_r     <= radix_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_beat_r <= out_beat_nxt;
  end

  // remainder store, least significant digit first
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[cnt_r[IDX_W-1:0]] <= div_rsp.remainder;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

`ifndef SYNTH
  // divider must be idle during readout
  a_emit_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !div_rsp.busy)
    else $error("divider busy during digit readout");

  // an error beat is always the last of its run
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_base) |-> out_data.last_digit)
    else $error("bad base beat without last_digit");

  // bad base goes straight to readout with no division
  a_bad_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && base_bad) |=> ((state_r == ST_EMIT) && err_r && !div_rsp.busy))
    else $error("bad base did not go straight to readout");

  // digit count never exceeds the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QW))
    else $error("digit count beyond store depth");
`endif

endmodule
`default_nettype wire

/* dv/tb_radix_digit_converter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_radix_digit_converter: self-checking bench for the radix digit converter
// A queue-fed driver sends {value, base} beats, a software divider predicts
// the ascii digit beats of each conversion, and a monitor compares every
// output beat in order. Both sides idle at random; long output stalls
// back the converter up, and the sender drains fully between phases.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter;
  import rdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 300;
  localparam int LONG_HOLD      = 600;
  localparam int IDLE_PERCENT   = 29;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  in_beat_t  conv_jobs[$];
  out_beat_t digits_due[$];
  int        mismatch_count = 0;
  int        beats_seen     = 0;
  int        hold_left      = 0;
  int        cycle_count    = 0;
  int        idle_cycles    = 0;

  radix_digit_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // no random idling inside this window
  function automatic bit calm_window();
    return (cycle_count >= 2000) && (cycle_count < 6000);
  endfunction

  // ascii glyph of one digit value
  function automatic logic [CHAR_BITS-1:0] digit_glyph(logic [RDIG_BITS-1:0] d);
    if (d < 4'd10) return 7'h30 + CHAR_BITS'(d);         // '0'..'9'
    return 7'h41 + CHAR_BITS'(d) - 7'd10;                 // 'A'..'F'
  endfunction

  // repeated division, digits queued most significant first
  function automatic void predict_digits(in_beat_t job);
    logic [VALUE_BITS-1:0] quot;
    logic [RDIG_BITS-1:0]  rems[16];
    int                    n;
    out_beat_t             beat;
    if (job.base < BASE_MIN || job.base > BASE_MAX) begin
      beat.digit_char = ERR_CHAR;
      beat.last_digit = 1'b1;
      beat.bad_base   = 1'b1;
      digits_due.push_back(beat);
      return;
    end
    quot = job.value;
    n    = 0;
    do begin
      rems[n] = RDIG_BITS'(quot % job.base);
      quot    = quot / job.base;
      n++;
    end while (quot != 0 && n < 16);
    for (int k = n - 1; k >= 0; k--) begin
      beat.digit_char = digit_glyph(rems[k]);
      beat.last_digit = (k == 0);
      beat.bad_base   = 1'b0;
      digits_due.push_back(beat);
    end
  endfunction

  // input driver, predicts on each accepted beat
  always @(posedge clk) begin
    logic     nxt_valid;
    in_beat_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_data  = in_data;
      if (in_valid && in_ready) begin
        predict_digits(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && conv_jobs.size() > 0 &&
          (calm_window() || $urandom_range(99) >= IDLE_PERCENT)) begin
        nxt_data  = conv_jobs.pop_front();
        nxt_valid = 1'b1;
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // output monitor and ready generation
  always @(posedge clk) begin
    out_beat_t want;
    logic      nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (beats_seen % 1500 == 40) hold_left = LONG_HOLD;
        if (digits_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected beat: got char=%h last=%b bad=%b",
                     out_data.digit_char, out_data.last_digit, out_data.bad_base);
        end else begin
          want = digits_due.pop_front();
          if (out_data.digit_char != want.digit_char ||
              out_data.last_digit != want.last_digit ||
              out_data.bad_base   != want.bad_base) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("beat %0d: expected char=%h last=%b bad=%b, got char=%h last=%b bad=%b",
                       beats_seen, want.digit_char, want.last_digit, want.bad_base,
                       out_data.digit_char, out_data.last_digit, out_data.bad_base);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = calm_window() || ($urandom_range(99) >= IDLE_PERCENT);
      end
      out_ready <= nxt_ready;
    end
  end

  // cycle count and watchdog on handshake activity
  always @(posedge clk) begin
    cycle_count++;
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // queue one conversion
  task automatic add_job(logic [VALUE_BITS-1:0] value, logic [BASE_BITS-1:0] base);
    in_beat_t job;
    job.value = value;
    job.base  = base;
    conv_jobs.push_back(job);
  endtask

  // random conversions, mostly legal bases
  task automatic add_random_jobs(int count);
    logic [VALUE_BITS-1:0] value;
    logic [BASE_BITS-1:0]  base;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0:       value = VALUE_BITS'($urandom_range(16'hffff));
        1:       value = VALUE_BITS'($urandom_range(255));
        2:       value = VALUE_BITS'($urandom_range(15));
        default: value = 16'hffff - VALUE_BITS'($urandom_range(31));
      endcase
      if ($urandom_range(99) < 15)
        base = BASE_BITS'($urandom_range(31));
      else
        base = BASE_BITS'($urandom_range(BASE_MAX, BASE_MIN));
      add_job(value, base);
    end
  endtask

  // wait until every queued beat is sent and every digit has come back
  task automatic wait_drained();
    while (conv_jobs.size() > 0 || in_valid || digits_due.size() > 0)
      @(posedge clk);
  endtask

  // reset and stimulus phases
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero, extremes, every glyph, bad bases
    add_job(16'd0, 5'd2);
    add_job(16'd0, 5'd10);
    add_job(16'd0, 5'd16);
    add_job(16'hffff, 5'd2);
    add_job(16'hffff, 5'd3);
    add_job(16'hffff, 5'd10);
    add_job(16'hffff, 5'd16);
    add_job(16'd1, 5'd2);
    add_job(16'h8000, 5'd2);
    add_job(16'haaaa, 5'd2);
    add_job(16'h5555, 5'd7);
    add_job(16'd15, 5'd16);
    add_job(16'd16, 5'd16);
    add_job(16'hfedc, 5'd16);
    add_job(16'hba98, 5'd16);
    add_job(16'h7654, 5'd16);
    add_job(16'h3210, 5'd16);
    add_job(16'd12345, 5'd10);
    add_job(16'd224, 5'd15);
    add_job(16'd1234, 5'd0);
    add_job(16'hffff, 5'd1);
    add_job(16'd0, 5'd17);
    add_job(16'h5a5a, 5'd31);
    wait_drained();

    // random, with a full drain between halves
    add_random_jobs(180);
    wait_drained();
    add_random_jobs(180);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digits_due.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
